/* design/http_byte_range_parser_assert.svh */
// assertion helpers for the byte range parser
`ifndef HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_ASSERT_SVH

// same-cycle implication, masked during reset
`define HBR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte range parser: check failed");

// next-cycle implication, not masked
`define HBR_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("byte range parser: check failed");

`endif

/* design/hbr_pkg.sv */
`timescale 1ns / 1ps

package hbr_pkg;

   localparam int BYTE_BITS     = 8;
   localparam int OUT_BITS      = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_LSB = 2;
   localparam int POS_BITS      = 3;
   localparam int DIGIT_BITS    = 4;
   // room for value * 10 + digit above the number width
   localparam int GROW_BITS     = 4;

   localparam logic [0:0] REG_FILE_SIZE = 1'b0;

   localparam logic [POS_BITS-1:0] PREFIX_LEN = POS_BITS'(6);

   localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_BITS-1:0] CHAR_DASH  = "-";
   localparam logic [BYTE_BITS-1:0] CHAR_COMMA = ",";
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = " ";
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = "0";
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = "9";

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_DASH,
      CLS_SEP,
      CLS_OTHER
   } hbr_class_type;

   // parse summary handed from the parser to the range decision
   typedef struct packed {
      logic empty;
      logic prefix_done;
      logic spec_nonempty;
      logic dash_seen;
      logic error_flag;
      logic first_has_digit;
      logic second_has_digit;
   } hbr_flags_type;

   // expected text "bytes=" one character per position
   function automatic logic [BYTE_BITS-1:0] prefix_char(input logic [POS_BITS-1:0] pos);
      logic [BYTE_BITS-1:0] c;
      case (pos)
         3'd0: c = "b";
         3'd1: c = "y";
         3'd2: c = "t";
         3'd3: c = "e";
         3'd4: c = "s";
         3'd5: c = "=";
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic hbr_class_type byte_class(input logic [BYTE_BITS-1:0] b);
      hbr_class_type cls;
      if (b == CHAR_COMMA || b == CHAR_SPACE || b == CHAR_TAB) begin
         cls = CLS_SEP;
      end else if (b == CHAR_DASH) begin
         cls = CLS_DASH;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

/* design/hbr_if.sv */
`timescale 1ns / 1ps

interface hbr_req_if import hbr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] header_byte;
   logic                 has_byte;
   logic                 last;

   modport source (output valid, output header_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input header_byte, input has_byte, input last,
                   output ready);
endinterface

interface hbr_rsp_if import hbr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                ok;
   logic                partial;
   logic [OUT_BITS-1:0] range_start;
   logic [OUT_BITS-1:0] range_length;

   modport source (output valid, output ok, output partial, output range_start,
                   output range_length, input ready);
   modport sink   (input valid, input ok, input partial, input range_start,
                   input range_length, output ready);
endinterface

/* design/http_byte_range_parser.sv */
`timescale 1ns / 1ps
// channel    dir  transfer when        payload
// req_chan   in   valid && ready       header_byte[7:0], has_byte, last
// rsp_chan   out  valid && ready       ok, partial, range_start[31:0], range_length[31:0]
// csr_*      in   psel&penable&pwrite  file_size at byte address 0
//
// one header byte per cycle while no last item waits on a full snapshot reg; a result passes
// through the input reg, snapshot reg and result reg after the item marked last is transferred
// synchronous active-high reset clears all valid flags and the parse state, file_size to 0
// a stalled result only holds up a last item once snapshot and result regs are both full
// items without last never wait on the result side

`include "http_byte_range_parser_assert.svh"

module http_byte_range_parser import hbr_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   hbr_req_if.sink                  req_chan,
   hbr_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [OUT_BITS-1:0]  file_size_ff;
   logic                 csr_hit;

   logic                 snap_valid;
   logic                 snap_ready;
   hbr_flags_type        snap_flags;
   logic [SIZE_BITS-1:0] snap_first;
   logic [SIZE_BITS-1:0] snap_second;

   logic [OUT_BITS:0]    rsp_end;
   logic                 rsp_part;
   logic                 rsp_full;
   logic                 rsp_fits;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_INDEX_LSB] == REG_FILE_SIZE);
   assign csr_prdata = csr_hit ? file_size_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         file_size_ff <= csr_pwdata;
      end
   end

   hbr_parse #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .snap_ready  (snap_ready),
      .snap_valid  (snap_valid),
      .snap_flags  (snap_flags),
      .snap_first  (snap_first),
      .snap_second (snap_second)
   );

   hbr_decide #(
      .SIZE_BITS (SIZE_BITS)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap_flags  (snap_flags),
      .snap_first  (snap_first),
      .snap_second (snap_second),
      .file_size   (file_size_ff),
      .snap_ready  (snap_ready),
      .rsp_chan    (rsp_chan)
   );

   assign rsp_end  = {1'b0, rsp_chan.range_start} + {1'b0, rsp_chan.range_length};
   assign rsp_part = rsp_chan.valid && rsp_chan.partial;
   assign rsp_full = rsp_chan.valid && !rsp_chan.partial;
   assign rsp_fits = (rsp_chan.range_length != '0) && !rsp_end[OUT_BITS];

   // a sub-range never runs past the 32-bit offset space and is never empty
   `HBR_ASSERT_IMPLIES(a_partial_fits, clock, reset, rsp_part, rsp_fits)
   `HBR_ASSERT_IMPLIES(a_partial_ok, clock, reset, rsp_part, rsp_chan.ok)
   `HBR_ASSERT_IMPLIES(a_full_start, clock, reset, rsp_full, rsp_chan.range_start == '0)
   `HBR_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_chan.valid && req_chan.ready)

endmodule

/* design/hbr_parse.sv */
`timescale 1ns / 1ps

module hbr_parse import hbr_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   hbr_req_if.sink              req_chan,
   input  logic                 snap_ready,
   output logic                 snap_valid,
   output hbr_flags_type        snap_flags,
   output logic [SIZE_BITS-1:0] snap_first,
   output logic [SIZE_BITS-1:0] snap_second
);

   localparam int EXT_BITS = SIZE_BITS + GROW_BITS;

   // input register
   logic                 in_valid_ff;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_has_ff;
   logic                 in_last_ff;
   logic                 in_fire;

   // running parse state
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 dash_ff, dash_in;
   logic                 err_ff, err_in;
   logic [SIZE_BITS-1:0] first_ff, first_in;
   logic                 first_has_ff, first_has_in;
   logic [SIZE_BITS-1:0] second_ff, second_in;
   logic                 second_has_ff, second_has_in;

   // snapshot taken at the last byte
   logic                 snap_valid_ff;
   hbr_flags_type        snap_flags_ff, snap_flags_in;
   logic [SIZE_BITS-1:0] snap_first_ff;
   logic [SIZE_BITS-1:0] snap_second_ff;

   logic [DIGIT_BITS-1:0] digit;
   logic [EXT_BITS-1:0]   num_ext;
   logic [EXT_BITS-1:0]   num_sum;
   logic                  overflow;
   hbr_class_type         cls;

   // a last byte needs the snapshot slot, other bytes only touch the state
   assign in_fire        = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_ready);
   assign req_chan.ready = !in_valid_ff || in_fire;

   assign cls      = byte_class(in_byte_ff);
   assign digit    = DIGIT_BITS'(in_byte_ff - CHAR_ZERO);
   assign num_ext  = EXT_BITS'(dash_ff ? second_ff : first_ff);
   // times ten as two shifts, then the new digit
   assign num_sum  = (num_ext << 3) + (num_ext << 1) + EXT_BITS'(digit);
   assign overflow = |num_sum[EXT_BITS-1:SIZE_BITS];

   always_comb begin
      pos_in        = pos_ff;
      nonempty_in   = nonempty_ff;
      dash_in       = dash_ff;
      err_in        = err_ff;
      first_in      = first_ff;
      first_has_in  = first_has_ff;
      second_in     = second_ff;
      second_has_in = second_has_ff;
      if (in_has_ff && !err_ff) begin
         if (pos_ff < PREFIX_LEN) begin
            if (in_byte_ff == prefix_char(pos_ff)) begin
               pos_in = pos_ff + POS_BITS'(1);
            end else begin
               err_in = 1'b1;
            end
         end else begin
            nonempty_in = 1'b1;
            case (cls)
               CLS_SEP: begin
                  err_in = 1'b1;
               end
               CLS_DASH: begin
                  if (dash_ff) begin
                     err_in = 1'b1;
                  end else begin
                     dash_in = 1'b1;
                  end
               end
               CLS_DIGIT: begin
                  if (overflow) begin
                     err_in = 1'b1;
                  end else if (dash_ff) begin
                     second_in     = num_sum[SIZE_BITS-1:0];
                     second_has_in = 1'b1;
                  end else begin
                     first_in     = num_sum[SIZE_BITS-1:0];
                     first_has_in = 1'b1;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
      end

      snap_flags_in.empty            = (pos_ff == '0) && !err_ff && !in_has_ff;
      snap_flags_in.prefix_done      = (pos_in == PREFIX_LEN);
      snap_flags_in.spec_nonempty    = nonempty_in;
      snap_flags_in.dash_seen        = dash_in;
      snap_flags_in.error_flag       = err_in;
      snap_flags_in.first_has_digit  = first_has_in;
      snap_flags_in.second_has_digit = second_has_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         pos_ff        <= '0;
         nonempty_ff   <= 1'b0;
         dash_ff       <= 1'b0;
         err_ff        <= 1'b0;
         first_ff      <= '0;
         first_has_ff  <= 1'b0;
         second_ff     <= '0;
         second_has_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (in_fire && in_last_ff) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
         if (in_fire) begin
            if (in_last_ff) begin
               // header done, start clean for the next one
               pos_ff        <= '0;
               nonempty_ff   <= 1'b0;
               dash_ff       <= 1'b0;
               err_ff        <= 1'b0;
               first_ff      <= '0;
               first_has_ff  <= 1'b0;
               second_ff     <= '0;
               second_has_ff <= 1'b0;
            end else begin
               pos_ff        <= pos_in;
               nonempty_ff   <= nonempty_in;
               dash_ff       <= dash_in;
               err_ff        <= err_in;
               first_ff      <= first_in;
               first_has_ff  <= first_has_in;
               second_ff     <= second_in;
               second_has_ff <= second_has_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.header_byte;
         in_has_ff  <= req_chan.has_byte;
         in_last_ff <= req_chan.last;
      end
      if (in_fire && in_last_ff) begin
         snap_flags_ff  <= snap_flags_in;
         snap_first_ff  <= first_in;
         snap_second_ff <= second_in;
      end
   end

   assign snap_valid  = snap_valid_ff;
   assign snap_flags  = snap_flags_ff;
   assign snap_first  = snap_first_ff;
   assign snap_second = snap_second_ff;

endmodule

/* design/hbr_decide.sv */
`timescale 1ns / 1ps

module hbr_decide import hbr_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 snap_valid,
   input  hbr_flags_type        snap_flags,
   input  logic [SIZE_BITS-1:0] snap_first,
   input  logic [SIZE_BITS-1:0] snap_second,
   input  logic [OUT_BITS-1:0]  file_size,
   output logic                 snap_ready,
   hbr_rsp_if.source            rsp_chan
);

   localparam int CMP_BITS = (SIZE_BITS > OUT_BITS) ? SIZE_BITS : OUT_BITS;

   logic                rsp_valid_ff;
   logic                ok_ff, ok_in;
   logic                partial_ff, partial_in;
   logic [OUT_BITS-1:0] start_ff, start_in;
   logic [OUT_BITS-1:0] length_ff, length_in;

   logic [CMP_BITS-1:0] fs_w;
   logic [CMP_BITS-1:0] first_w;
   logic [CMP_BITS-1:0] second_w;
   logic [OUT_BITS-1:0] fs_last;
   logic [OUT_BITS-1:0] suffix_sel;
   logic [OUT_BITS-1:0] end_pos;
   logic                base_fail;
   logic                good;
   logic [OUT_BITS-1:0] good_start;
   logic [OUT_BITS-1:0] good_length;

   assign snap_ready = !rsp_valid_ff || rsp_chan.ready;

   assign fs_w     = CMP_BITS'(file_size);
   assign first_w  = CMP_BITS'(snap_first);
   assign second_w = CMP_BITS'(snap_second);
   assign fs_last  = file_size - OUT_BITS'(1);

   always_comb begin
      base_fail = snap_flags.error_flag || !snap_flags.prefix_done || (file_size == '0) ||
                  !snap_flags.spec_nonempty || !snap_flags.dash_seen;
      suffix_sel = (second_w < fs_w) ? second_w[OUT_BITS-1:0] : file_size;
      end_pos    = fs_last;
      if (snap_flags.second_has_digit && (second_w < fs_w)) begin
         end_pos = second_w[OUT_BITS-1:0];
      end
      if (!snap_flags.first_has_digit) begin
         // suffix form: last N bytes
         good        = snap_flags.second_has_digit && (second_w != '0);
         good_start  = file_size - suffix_sel;
         good_length = suffix_sel;
      end else begin
         good = (first_w < fs_w) &&
                !(snap_flags.second_has_digit && (second_w < first_w));
         good_start  = first_w[OUT_BITS-1:0];
         good_length = end_pos - first_w[OUT_BITS-1:0] + OUT_BITS'(1);
      end
      good = good && !base_fail;

      if (!snap_flags.empty && good) begin
         ok_in      = 1'b1;
         partial_in = 1'b1;
         start_in   = good_start;
         length_in  = good_length;
      end else begin
         ok_in      = snap_flags.empty;
         partial_in = 1'b0;
         start_in   = '0;
         length_in  = file_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         ok_ff      <= ok_in;
         partial_ff <= partial_in;
         start_ff   <= start_in;
         length_ff  <= length_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = ok_ff;
   assign rsp_chan.partial      = partial_ff;
   assign rsp_chan.range_start  = start_ff;
   assign rsp_chan.range_length = length_ff;

endmodule

/* verif/http_byte_range_parser_test.sv */
`timescale 1ns / 1ps

module http_byte_range_parser_test;
   import hbr_pkg::*;

   localparam int SIZE_BITS      = 32;
   localparam logic [63:0] NUM_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;
   localparam logic [47:0] UNIT_TEXT = "bytes=";
   localparam int DRAIN_CYCLES   = 12;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FILE_SIZE =
      CSR_ADDR_BITS'(int'(REG_FILE_SIZE) << CSR_INDEX_LSB);

   typedef struct packed {
      logic [BYTE_BITS-1:0] hdr_byte;
      logic                 has;
      logic                 last;
   } header_item_type;

   typedef struct packed {
      logic                ok;
      logic                partial;
      logic [OUT_BITS-1:0] range_start;
      logic [OUT_BITS-1:0] range_length;
   } range_result_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   hbr_req_if req_chan ();
   hbr_rsp_if rsp_chan ();

   http_byte_range_parser #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   header_item_type  header_items[$];
   range_result_type range_expected[$];
   logic [BYTE_BITS-1:0] hdr_text[$];

   // predictor copy of the register and the parse state
   logic [31:0]         size_reg;
   logic [POS_BITS-1:0] parse_pos;
   logic                parse_spec;
   logic                parse_dash;
   logic                parse_err;
   logic [63:0]         lo_num;
   logic                lo_has;
   logic [63:0]         hi_num;
   logic                hi_has;

   int send_idle_pct;
   int recv_stall_pct;
   logic hold_rsp;
   int hold_count;
   int idle_cycles;
   int errors;
   header_item_type  drv_item;
   range_result_type got_exp;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parse();
      parse_pos  = '0;
      parse_spec = 1'b0;
      parse_dash = 1'b0;
      parse_err  = 1'b0;
      lo_num     = '0;
      lo_has     = 1'b0;
      hi_num     = '0;
      hi_has     = 1'b0;
   endfunction

   function automatic void add_digit(inout logic [63:0] num, inout logic has,
                                     input logic [63:0] dig);
      if (num > (NUM_LIMIT - dig) / 64'd10) begin
         parse_err = 1'b1;
      end else begin
         num = num * 64'd10 + dig;
         has = 1'b1;
      end
   endfunction

   function automatic void parse_header_byte(input logic [BYTE_BITS-1:0] b);
      logic [63:0] dig;
      dig = 64'(b - CHAR_ZERO);
      if (parse_err) return;
      if (parse_pos < PREFIX_LEN) begin
         if (b == UNIT_TEXT[8*(5-int'(parse_pos)) +: 8]) parse_pos = parse_pos + 1'b1;
         else parse_err = 1'b1;
         return;
      end
      parse_spec = 1'b1;
      if (b == CHAR_COMMA || b == CHAR_SPACE || b == CHAR_TAB) begin
         parse_err = 1'b1;
      end else if (b == CHAR_DASH) begin
         if (parse_dash) parse_err = 1'b1;
         else parse_dash = 1'b1;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         if (parse_dash) add_digit(hi_num, hi_has, dig);
         else add_digit(lo_num, lo_has, dig);
      end else begin
         parse_err = 1'b1;
      end
   endfunction

   function automatic range_result_type resolve_range(input logic empty);
      range_result_type r;
      logic [63:0] fs;
      logic [63:0] e;
      logic [63:0] sel;
      fs = {32'b0, size_reg};
      r = '{ok: empty, partial: 1'b0, range_start: '0, range_length: size_reg};
      if (empty || parse_err || parse_pos < PREFIX_LEN || fs == 0 || !parse_spec ||
          !parse_dash) return r;
      if (!lo_has) begin
         if (!hi_has || hi_num == 0) return r;
         sel = (hi_num < fs) ? hi_num : fs;
         r = '{ok: 1'b1, partial: 1'b1, range_start: 32'(fs - sel), range_length: 32'(sel)};
         return r;
      end
      if (lo_num >= fs) return r;
      e = hi_has ? hi_num : fs - 64'd1;
      if (hi_has && e < lo_num) return r;
      if (e >= fs) e = fs - 64'd1;
      r = '{ok: 1'b1, partial: 1'b1, range_start: 32'(lo_num),
            range_length: 32'(e - lo_num + 64'd1)};
      return r;
   endfunction

   function automatic void track_item(input header_item_type it);
      logic empty;
      if (!it.last) begin
         if (it.has) parse_header_byte(it.hdr_byte);
         return;
      end
      empty = (parse_pos == 0) && !parse_err;
      if (it.has) begin
         parse_header_byte(it.hdr_byte);
         empty = 1'b0;
      end
      range_expected.push_back(resolve_range(empty));
      clear_parse();
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) hdr_text.push_back(s[i]);
   endfunction

   function automatic void append_dec(input logic [63:0] v);
      logic [BYTE_BITS-1:0] digs[$];
      int zeros;
      zeros = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      do begin
         digs.push_front(CHAR_ZERO + 8'(v % 64'd10));
         v = v / 64'd10;
      end while (v != 0);
      repeat (zeros) digs.push_front(CHAR_ZERO);
      foreach (digs[i]) hdr_text.push_back(digs[i]);
   endfunction

   function automatic logic [63:0] pick_number();
      logic [63:0] fs;
      logic [63:0] v;
      fs = {32'b0, size_reg};
      case ($urandom_range(9))
         0: v = 64'd0;
         1: v = 64'd1;
         2: v = (fs == 0) ? 64'd0 : fs - 64'd1;
         3: v = fs;
         4: v = fs + 64'd1;
         5: v = 64'($urandom_range(size_reg));
         6: v = 64'($urandom);
         7: v = NUM_LIMIT;
         8: v = NUM_LIMIT + 64'd1 + 64'($urandom_range(9));
         default: v = 64'($urandom_range(20));
      endcase
      return v;
   endfunction

   // turns the text into items; returns the count of items that carry meaning
   function automatic int emit_header(input logic term_item);
      int n;
      n = 0;
      foreach (hdr_text[i]) begin
         if ($urandom_range(19) == 0)
            header_items.push_back('{8'($urandom_range(1, 255)), 1'b0, 1'b0});
         header_items.push_back('{hdr_text[i], 1'b1,
                                  (i == hdr_text.size() - 1) && !term_item});
         n++;
      end
      if (term_item) begin
         header_items.push_back('{8'($urandom_range(1, 255)), 1'b0, 1'b1});
         n++;
      end
      return n;
   endfunction

   function automatic int add_random_header();
      int kind;
      int form;
      logic [63:0] a;
      logic [63:0] b;
      int pos;
      hdr_text.delete();
      kind = $urandom_range(99);
      if (kind < 6) return emit_header(1'b1);
      append_text("bytes=");
      form = $urandom_range(2);
      a = pick_number();
      if (form != 0) append_dec(a);
      hdr_text.push_back(CHAR_DASH);
      if (form == 0) begin
         append_dec(pick_number());
      end else if (form == 2) begin
         case ($urandom_range(3))
            0: b = a + 64'($urandom_range(50));
            1: b = (a == 0) ? 64'd0 : a - 64'd1;
            default: b = pick_number();
         endcase
         append_dec(b);
      end
      if (kind >= 70) begin
         pos = $urandom_range(hdr_text.size() - 1);
         case ($urandom_range(8))
            0: hdr_text[pos] = 8'($urandom_range(1, 255));
            1: begin
               case ($urandom_range(2))
                  0: hdr_text.insert(pos, CHAR_COMMA);
                  1: hdr_text.insert(pos, CHAR_SPACE);
                  default: hdr_text.insert(pos, CHAR_TAB);
               endcase
            end
            2: hdr_text.insert($urandom_range(6, hdr_text.size()), CHAR_DASH);
            3: begin
               while (hdr_text.size() > pos + 1) void'(hdr_text.pop_back());
            end
            4: begin
               hdr_text.delete();
               append_text("bytes=");
            end
            5: begin
               hdr_text.delete();
               append_text("bytes=");
               append_dec(pick_number());
            end
            6: begin
               hdr_text.delete();
               append_text("bytes=");
               if ($urandom_range(1)) hdr_text.push_back(CHAR_DASH);
               repeat ($urandom_range(10, 14))
                  hdr_text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
               if ($urandom_range(1)) hdr_text.push_back(CHAR_DASH);
            end
            7: hdr_text[pos % 6] = hdr_text[pos % 6] ^ 8'h20;
            default: hdr_text.push_back(8'($urandom_range(1, 255)));
         endcase
      end
      return emit_header($urandom_range(3) == 0);
   endfunction

   function automatic void queue_random(input int n_items);
      int n;
      n = 0;
      while (n < n_items) n += add_random_header();
   endfunction

   function automatic void queue_text(input string s, input logic term_item);
      hdr_text.delete();
      append_text(s);
      void'(emit_header(term_item));
   endfunction

   task automatic write_file_size(input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_FILE_SIZE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      size_reg = value;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // sampled away from the rising edge so the driver and monitor have settled
   task automatic wait_drained();
      while (header_items.size() != 0 || req_chan.valid || range_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- channels

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (header_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_item = header_items.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.header_byte <= drv_item.hdr_byte;
            req_chan.has_byte    <= drv_item.has;
            req_chan.last        <= drv_item.last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         track_item('{req_chan.header_byte, req_chan.has_byte, req_chan.last});
   end

   // long hold is counted here so the sender keeps pushing meanwhile
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_chan.ready <= 1'b0;
         hold_count     <= hold_count + 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (range_expected.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            got_exp = range_expected.pop_front();
            if (rsp_chan.ok !== got_exp.ok) begin
               $error("ok: expected %0d, got %0d", got_exp.ok, rsp_chan.ok);
               errors++;
            end
            if (rsp_chan.partial !== got_exp.partial) begin
               $error("partial: expected %0d, got %0d", got_exp.partial, rsp_chan.partial);
               errors++;
            end
            if (rsp_chan.range_start !== got_exp.range_start) begin
               $error("range_start: expected %0d, got %0d", got_exp.range_start,
                      rsp_chan.range_start);
               errors++;
            end
            if (rsp_chan.range_length !== got_exp.range_length) begin
               $error("range_length: expected %0d, got %0d", got_exp.range_length,
                      rsp_chan.range_length);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.header_byte = '0;
      req_chan.has_byte    = 1'b0;
      req_chan.last        = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      hold_rsp             = 1'b0;
      hold_count           = 0;
      idle_cycles          = 0;
      errors               = 0;
      size_reg             = '0;
      clear_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_file_size(32'd1000);
      // empty header, ignored item, suffix, open-ended via end marker, junk byte
      header_items.push_back('{8'h41, 1'b0, 1'b1});
      header_items.push_back('{8'h80, 1'b0, 1'b0});
      queue_text("bytes=-5", 1'b0);
      queue_text("bytes=7-", 1'b1);
      header_items.push_back('{8'hFF, 1'b1, 1'b1});
      queue_random(200);
      wait_drained();

      write_file_size(32'd0);
      set_idle(67, 0);
      queue_random(150);
      wait_drained();

      write_file_size(32'hFFFF_FFFF);
      set_idle(0, 67);
      queue_random(150);
      wait_drained();
      queue_random(150);
      wait_drained();

      write_file_size(32'd1);
      set_idle(37, 37);
      queue_random(120);
      wait_drained();

      write_file_size($urandom);
      queue_random(250);
      @(posedge clock);
      hold_rsp <= 1'b1;
      while (hold_count < LONG_HOLD) @(posedge clock);
      hold_rsp <= 1'b0;
      wait_drained();

      write_file_size($urandom_range(1, 64));
      set_idle(0, 0);
      queue_random(200);
      wait_drained();

      write_file_size(32'hFFFF_FFFE);
      set_idle(67, 67);
      queue_random(100);
      wait_drained();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
